// ===== hdl/gbre_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander package
// Shared sizes, register indexes, layout codes and transaction types.
// ----------------------------------------------------------------------------
package gbre_pkg;

   localparam int MAX_GLYPH_WIDTH  = 16;
   localparam int MAX_GLYPH_HEIGHT = 16;
   localparam int GLYPH_BYTES      = 32;

   localparam int BYTE_BITS  = 8;
   localparam int BYTE_MSB   = 7;
   localparam int BYTE_SHIFT = $clog2(BYTE_BITS);

   localparam int DIM_W        = 5;
   localparam int EFF_W        = DIM_W + 1;
   localparam int COORD_W      = 9;
   localparam int COLOR_W      = 16;
   localparam int MASK_W       = 16;
   localparam int ROW_INDEX_W  = 4;
   localparam int BYTE_IDX_W   = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = DIM_W;

   localparam int STORE_ADDR_W  = $clog2(GLYPH_BYTES);
   localparam int PIX_W         = $clog2(MAX_GLYPH_WIDTH);
   localparam int ROW_W         = $clog2(MAX_GLYPH_HEIGHT);
   localparam int STREAM_W      = $clog2(MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT);
   localparam int COL_BYTES_MAX = (MAX_GLYPH_HEIGHT + BYTE_MSB) / BYTE_BITS;
   localparam int COL_ADDR_W    = $clog2(MAX_GLYPH_WIDTH * COL_BYTES_MAX);
   localparam int LIMIT_W       = $clog2(GLYPH_BYTES + 1);
   localparam int STREAM_ADDR_W = STREAM_W - BYTE_SHIFT;
   localparam int ADDR_W_A      = (COL_ADDR_W > STREAM_ADDR_W) ? COL_ADDR_W : STREAM_ADDR_W;
   localparam int ADDR_W_B      = (LIMIT_W > BYTE_IDX_W) ? LIMIT_W : BYTE_IDX_W;
   localparam int ADDR_W        = (ADDR_W_A > ADDR_W_B) ? ADDR_W_A : ADDR_W_B;

   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT_MODE  = CSR_INDEX_W'(2);

   localparam logic [DIM_W-1:0] GLYPH_WIDTH_RESET  = DIM_W'(8);
   localparam logic [DIM_W-1:0] GLYPH_HEIGHT_RESET = DIM_W'(16);

   localparam logic LAYOUT_ROW_MAJOR = 1'b0;
   localparam logic LAYOUT_COL_MAJOR = 1'b1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic [BYTE_BITS-1:0]  byte_value;
      logic [COORD_W-1:0]    origin_x;
      logic [COORD_W-1:0]    origin_y;
      logic [COLOR_W-1:0]    draw_color;
   } req_type;

   typedef struct packed {
      logic                   is_window;
      logic [COORD_W-1:0]     x_start;
      logic [COORD_W-1:0]     x_end;
      logic [COORD_W-1:0]     y_start;
      logic [COORD_W-1:0]     y_end;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [MASK_W-1:0]      row_mask;
      logic [COLOR_W-1:0]     fg_color;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic draw_start;
      logic pixel_step;
      logic emit_window;
      logic emit_row;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic last_row;
   } status_type;

endpackage

// ===== hdl/glyph_bitmap_row_expander.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander
// Load: taken in any idle cycle, back to back; it gives no transaction.
// Draw: a window transaction after the start, then one row transaction per row
// (one glyph store read per pixel, then a drain step); busy until the last row.
// Reset (synchronous) idles the block and restores width 8, height 16, row-major
// layout; the glyph store keeps its contents. Results are never stalled.
// ----------------------------------------------------------------------------
module glyph_bitmap_row_expander (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  gbre_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output gbre_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [gbre_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbre_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   import gbre_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic                    ram_wr_en;
   logic [STORE_ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_BITS-1:0]    ram_wr_data;
   logic [STORE_ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_BITS-1:0]    ram_rd_data;

   gbre_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_data.kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   gbre_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_data    (rsp_data)
   );

   gbre_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (GLYPH_BYTES)
   ) u_glyph_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== hdl/gbre_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gbre_controller.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander controller
// Sequences window, pixel read, drain and row emission steps of a draw.
// ----------------------------------------------------------------------------
module gbre_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_kind,
   input  gbre_pkg::status_type status,
   output gbre_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   import gbre_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_PIXEL,
      ST_DRAIN,
      ST_ROW
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd.load        = accept && (req_kind == KIND_LOAD);
      cmd.draw_start  = accept && (req_kind == KIND_DRAW);
      cmd.pixel_step  = (state_ff == ST_PIXEL);
      cmd.emit_window = (state_ff == ST_WINDOW);
      cmd.emit_row    = (state_ff == ST_ROW);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.draw_start) begin
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (status.last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (status.last_row) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PIXEL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in   = (state_in != ST_IDLE);
      strobe_in = cmd.emit_window || cmd.emit_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== hdl/gbre_datapath.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander datapath
// Holds configuration, walks glyph pixels and assembles transactions.
// ----------------------------------------------------------------------------
module gbre_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [gbre_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gbre_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  gbre_pkg::req_type                    req_data,
   input  gbre_pkg::cmd_type                    cmd,
   output gbre_pkg::status_type                 status,
   output logic                                 ram_wr_en,
   output logic [gbre_pkg::STORE_ADDR_W-1:0]    ram_wr_addr,
   output logic [gbre_pkg::BYTE_BITS-1:0]       ram_wr_data,
   output logic [gbre_pkg::STORE_ADDR_W-1:0]    ram_rd_addr,
   input  logic [gbre_pkg::BYTE_BITS-1:0]       ram_rd_data,
   output gbre_pkg::rsp_type                    rsp_data
);

   import gbre_pkg::*;

   logic [DIM_W-1:0]           width_ff, width_in;
   logic [DIM_W-1:0]           height_ff, height_in;
   logic                       mode_ff, mode_in;
   logic [EFF_W-1:0]           w_eff, h_eff, col_step;
   logic [COORD_W-1:0]         ox_ff, ox_in, oy_ff, oy_in;
   logic [COLOR_W-1:0]         color_ff, color_in;
   logic [PIX_W-1:0]           pix_ff, pix_in;
   logic [ROW_W-1:0]           row_ff, row_in, row_next;
   logic [STREAM_W-1:0]        stream_ff, stream_in;
   logic [ADDR_W-1:0]          col_ff, col_in;
   logic [ADDR_W-1:0]          rd_addr_full, load_addr_full;
   logic [BYTE_SHIFT-1:0]      rd_bit;
   logic                       rd_hit;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       pend_hit_ff, pend_hit_in;
   logic [PIX_W-1:0]           pend_pix_ff, pend_pix_in;
   logic [BYTE_SHIFT-1:0]      pend_bit_ff, pend_bit_in;
   logic [MAX_GLYPH_WIDTH-1:0] mask_ff, mask_in;
   rsp_type                    rsp_ff, rsp_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GLYPH_WIDTH:  width_in  = csr_wr_data;
            CSR_GLYPH_HEIGHT: height_in = csr_wr_data;
            CSR_LAYOUT_MODE:  mode_in   = csr_wr_data[0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = EFF_W'(1);
      end else if (EFF_W'(width_ff) > EFF_W'(MAX_GLYPH_WIDTH)) begin
         w_eff = EFF_W'(MAX_GLYPH_WIDTH);
      end else begin
         w_eff = EFF_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = EFF_W'(1);
      end else if (EFF_W'(height_ff) > EFF_W'(MAX_GLYPH_HEIGHT)) begin
         h_eff = EFF_W'(MAX_GLYPH_HEIGHT);
      end else begin
         h_eff = EFF_W'(height_ff);
      end
      col_step = (h_eff + EFF_W'(BYTE_MSB)) >> BYTE_SHIFT;
   end

   assign status.last_pixel = (EFF_W'(pix_ff) == (w_eff - EFF_W'(1)));
   assign status.last_row   = (EFF_W'(row_ff) == (h_eff - EFF_W'(1)));

   always_comb begin
      if (mode_ff == LAYOUT_COL_MAJOR) begin
         rd_addr_full = col_ff;
         rd_bit       = row_ff[BYTE_SHIFT-1:0];
      end else begin
         rd_addr_full = ADDR_W'(stream_ff >> BYTE_SHIFT);
         rd_bit       = BYTE_SHIFT'(BYTE_MSB) - stream_ff[BYTE_SHIFT-1:0];
      end
      rd_hit = (rd_addr_full < ADDR_W'(GLYPH_BYTES));
   end

   assign ram_rd_addr    = rd_addr_full[STORE_ADDR_W-1:0];
   assign load_addr_full = ADDR_W'(req_data.byte_index);
   assign ram_wr_en      = cmd.load && (load_addr_full < ADDR_W'(GLYPH_BYTES));
   assign ram_wr_addr    = load_addr_full[STORE_ADDR_W-1:0];
   assign ram_wr_data    = req_data.byte_value;

   assign row_next = row_ff + ROW_W'(1);

   always_comb begin
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      color_in  = color_ff;
      pix_in    = pix_ff;
      row_in    = row_ff;
      stream_in = stream_ff;
      col_in    = col_ff;
      if (cmd.draw_start) begin
         ox_in     = req_data.origin_x;
         oy_in     = req_data.origin_y;
         color_in  = req_data.draw_color;
         pix_in    = '0;
         row_in    = '0;
         stream_in = '0;
         col_in    = '0;
      end else if (cmd.pixel_step) begin
         pix_in    = pix_ff + PIX_W'(1);
         stream_in = stream_ff + STREAM_W'(1);
         col_in    = col_ff + ADDR_W'(col_step);
      end else if (cmd.emit_row) begin
         pix_in = '0;
         row_in = row_next;
         col_in = ADDR_W'(row_next >> BYTE_SHIFT);
      end
   end

   always_comb begin
      pend_valid_in = cmd.pixel_step;
      pend_hit_in   = rd_hit;
      pend_pix_in   = pix_ff;
      pend_bit_in   = rd_bit;
      mask_in       = mask_ff;
      if (cmd.draw_start || cmd.emit_row) begin
         mask_in = '0;
      end else if (pend_valid_ff && pend_hit_ff && ram_rd_data[pend_bit_ff]) begin
         mask_in[pend_pix_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_window) begin
         rsp_in           = '0;
         rsp_in.is_window = 1'b1;
         rsp_in.x_start   = ox_ff;
         rsp_in.x_end     = ox_ff + COORD_W'(w_eff) - COORD_W'(1);
         rsp_in.y_start   = oy_ff;
         rsp_in.y_end     = oy_ff + COORD_W'(h_eff) - COORD_W'(1);
      end else if (cmd.emit_row) begin
         rsp_in           = '0;
         rsp_in.row_index = ROW_INDEX_W'(row_ff);
         rsp_in.row_mask  = MASK_W'(mask_ff);
         rsp_in.fg_color  = color_ff;
         rsp_in.last      = status.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= GLYPH_WIDTH_RESET;
         height_ff     <= GLYPH_HEIGHT_RESET;
         mode_ff       <= LAYOUT_ROW_MAJOR;
         pend_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      color_ff    <= color_in;
      pix_ff      <= pix_in;
      row_ff      <= row_in;
      stream_ff   <= stream_in;
      col_ff      <= col_in;
      pend_hit_ff <= pend_hit_in;
      pend_pix_ff <= pend_pix_in;
      pend_bit_ff <= pend_bit_in;
      mask_ff     <= mask_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/gbre_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander checker
// Port-level properties of loads and of the draw sequence, bound to the top level.
// ----------------------------------------------------------------------------
module gbre_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input gbre_pkg::req_type                req_data,
   input logic                             rsp_strobe,
   input gbre_pkg::rsp_type                rsp_data,
   input logic                             csr_wr_en,
   input logic [gbre_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [gbre_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   import gbre_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_draw_gives_window: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == KIND_DRAW) |-> ##2 (rsp_strobe && rsp_data.is_window))
      else $error("draw transaction not followed by its window");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == KIND_LOAD) |=> !rsp_strobe)
      else $error("load transaction produced a result");

   a_window_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.is_window |-> busy)
      else $error("window result outside a draw");

   a_last_ends_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_window && rsp_data.last |-> !busy)
      else $error("draw still busy after its last row");

   a_idle_strobe_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !busy |-> rsp_data.last && $past(busy))
      else $error("result while idle that does not close a draw");

endmodule

bind glyph_bitmap_row_expander gbre_checker u_gbre_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_data    (req_data),
   .rsp_strobe  (rsp_strobe),
   .rsp_data    (rsp_data),
   .csr_wr_en   (csr_wr_en),
   .csr_index   (csr_index),
   .csr_wr_data (csr_wr_data)
);

// ===== verif/glyph_bitmap_row_expander_tb.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap row expander testbench
// Fills the glyph store, then walks a directed table of loads, draws and
// register settings (extremes, saturation, coordinate wrap, both layouts).
// Random phases follow: each phase has its own setting and gap pattern.
// Every draw is expanded here into its window and row transactions, and each
// strobed result is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module glyph_bitmap_row_expander_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbre_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int GAP_MAX = 13;
   localparam int RANDOM_ITEMS = 222;
   localparam int RANDOM_PHASES = 6;
   localparam int DRAW_PERCENT = 35;
   localparam int MAX_REPORTS = 100;

   typedef rsp_type glyph_beats_type[$];

   typedef enum logic [1:0] {
      STEP_CFG,
      STEP_LOAD,
      STEP_DRAW
   } step_kind_type;

   // p0: width / byte index / origin x, p1: height / byte value / origin y,
   // p2: layout / colour
   typedef struct packed {
      step_kind_type       kind;
      logic [COORD_W-1:0]  p0;
      logic [COORD_W-1:0]  p1;
      logic [COLOR_W-1:0]  p2;
      logic                typed;
      logic [COORD_W-1:0]  x_end;
      logic [COORD_W-1:0]  y_end;
   } dir_step_type;

   localparam int DIRECTED_ROWS = 25;
   localparam dir_step_type DIRECTED [DIRECTED_ROWS] = '{
      '{STEP_LOAD, 9'd0,   9'd255, 16'h0000, 1'b0, 9'd0,   9'd0  },
      '{STEP_LOAD, 9'd31,  9'd0,   16'h0000, 1'b0, 9'd0,   9'd0  },
      '{STEP_LOAD, 9'd16,  9'hA5,  16'h0000, 1'b0, 9'd0,   9'd0  },
      '{STEP_DRAW, 9'd0,   9'd0,   16'hFFFF, 1'b1, 9'd7,   9'd15 },
      '{STEP_DRAW, 9'd511, 9'd511, 16'h0000, 1'b1, 9'd6,   9'd14 },
      '{STEP_DRAW, 9'd319, 9'd319, 16'h8001, 1'b0, 9'd0,   9'd0  },
      '{STEP_CFG,  9'd16,  9'd31,  16'(LAYOUT_ROW_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd319, 9'd319, 16'hF800, 1'b1, 9'd334, 9'd334},
      '{STEP_DRAW, 9'd497, 9'd0,   16'h07E0, 1'b1, 9'd0,   9'd15 },
      '{STEP_CFG,  9'd16,  9'd16,  16'(LAYOUT_COL_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd100, 9'd200, 16'h001F, 1'b0, 9'd0,   9'd0  },
      '{STEP_CFG,  9'd0,   9'd0,   16'(LAYOUT_COL_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd5,   9'd6,   16'h1234, 1'b1, 9'd5,   9'd6  },
      '{STEP_CFG,  9'd0,   9'd0,   16'(LAYOUT_ROW_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd511, 9'd0,   16'hFFFF, 1'b1, 9'd511, 9'd0  },
      '{STEP_CFG,  9'd3,   9'd5,   16'(LAYOUT_ROW_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd10,  9'd20,  16'h5555, 1'b1, 9'd12,  9'd24 },
      '{STEP_CFG,  9'd31,  9'd9,   16'(LAYOUT_COL_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd1,   9'd2,   16'hAAAA, 1'b1, 9'd16,  9'd10 },
      '{STEP_CFG,  9'd7,   9'd8,   16'(LAYOUT_COL_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd256, 9'd128, 16'h0F0F, 1'b1, 9'd262, 9'd135},
      '{STEP_CFG,  9'd1,   9'd16,  16'(LAYOUT_ROW_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd0,   9'd304, 16'hF0F0, 1'b1, 9'd0,   9'd319},
      '{STEP_CFG,  9'd17,  9'd1,   16'(LAYOUT_ROW_MAJOR), 1'b0, 9'd0, 9'd0},
      '{STEP_DRAW, 9'd300, 9'd319, 16'h0001, 1'b1, 9'd315, 9'd319}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   logic [BYTE_BITS-1:0] store_image [GLYPH_BYTES];
   logic [DIM_W-1:0]     width_setting;
   logic [DIM_W-1:0]     height_setting;
   logic                 layout_setting;
   glyph_beats_type      beats_due;
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   bit                   gaps_on = 1'b1;

   glyph_bitmap_row_expander uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %0h want %0h",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      if (v == '0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   function automatic bit store_bit(input int addr, input int bit_pos);
      if (addr >= GLYPH_BYTES) return 1'b0;
      return store_image[addr][bit_pos & BYTE_MSB];
   endfunction

   function automatic void expect_draw(input req_type item, input bit typed,
                                       input logic [COORD_W-1:0] x_end_typed,
                                       input logic [COORD_W-1:0] y_end_typed);
      int                w;
      int                h;
      int                cb;
      int                b;
      bit                px;
      logic [MASK_W-1:0] mask;
      rsp_type           beat;
      w  = clamp_dim(width_setting, MAX_GLYPH_WIDTH);
      h  = clamp_dim(height_setting, MAX_GLYPH_HEIGHT);
      cb = (h + BYTE_MSB) / BYTE_BITS;
      beat           = '0;
      beat.is_window = 1'b1;
      beat.x_start   = item.origin_x;
      beat.x_end     = COORD_W'(int'(item.origin_x) + w - 1);
      beat.y_start   = item.origin_y;
      beat.y_end     = COORD_W'(int'(item.origin_y) + h - 1);
      if (typed) begin
         beat.x_end = x_end_typed;
         beat.y_end = y_end_typed;
      end
      beats_due.push_back(beat);
      for (int r = 0; r < h; r++) begin
         mask = '0;
         for (int k = 0; k < w; k++) begin
            if (layout_setting == LAYOUT_ROW_MAJOR) begin
               b  = r * w + k;
               px = store_bit(b >> BYTE_SHIFT, BYTE_MSB - (b & BYTE_MSB));
            end else begin
               px = store_bit(k * cb + (r >> BYTE_SHIFT), r & BYTE_MSB);
            end
            if (px) begin
               mask[k] = 1'b1;
            end
         end
         beat           = '0;
         beat.row_index = ROW_INDEX_W'(r);
         beat.row_mask  = mask;
         beat.fg_color  = item.draw_color;
         beat.last      = (r + 1 == h);
         beats_due.push_back(beat);
      end
   endfunction

   function automatic req_type random_req(input logic kind);
      req_type item;
      item.kind       = kind;
      item.byte_index = BYTE_IDX_W'($urandom_range(GLYPH_BYTES - 1, 0));
      item.byte_value = BYTE_BITS'($urandom);
      item.origin_x   = COORD_W'($urandom);
      item.origin_y   = COORD_W'($urandom);
      item.draw_color = COLOR_W'($urandom);
      return item;
   endfunction

   task automatic send_item(input req_type item, input bit typed,
                            input logic [COORD_W-1:0] x_end_typed,
                            input logic [COORD_W-1:0] y_end_typed);
      int gap;
      gap = gaps_on ? $urandom_range(GAP_MAX, 0) : 0;
      repeat (gap) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      csr_wr_en <= 1'b0;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (busy);
      if (item.kind == KIND_LOAD) begin
         store_image[item.byte_index] = item.byte_value;
      end else begin
         expect_draw(item, typed, x_end_typed, y_end_typed);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      start     <= 1'b0;
      csr_wr_en <= 1'b0;
      @(posedge clock);
      while (busy || beats_due.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      case (index)
         CSR_GLYPH_WIDTH: begin
            width_setting = value;
         end
         CSR_GLYPH_HEIGHT: begin
            height_setting = value;
         end
         CSR_LAYOUT_MODE: begin
            layout_setting = value[0];
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (beats_due.size() == 0) begin
            flag_mismatch("result with nothing due", 1, 0);
         end else begin
            want = beats_due.pop_front();
            if (rsp_data.is_window !== want.is_window)
               flag_mismatch("is_window", rsp_data.is_window, want.is_window);
            if (rsp_data.x_start !== want.x_start)
               flag_mismatch("x_start", rsp_data.x_start, want.x_start);
            if (rsp_data.x_end !== want.x_end)
               flag_mismatch("x_end", rsp_data.x_end, want.x_end);
            if (rsp_data.y_start !== want.y_start)
               flag_mismatch("y_start", rsp_data.y_start, want.y_start);
            if (rsp_data.y_end !== want.y_end)
               flag_mismatch("y_end", rsp_data.y_end, want.y_end);
            if (rsp_data.row_index !== want.row_index)
               flag_mismatch("row_index", rsp_data.row_index, want.row_index);
            if (rsp_data.row_mask !== want.row_mask)
               flag_mismatch("row_mask", rsp_data.row_mask, want.row_mask);
            if (rsp_data.fg_color !== want.fg_color)
               flag_mismatch("fg_color", rsp_data.fg_color, want.fg_color);
            if (rsp_data.last !== want.last)
               flag_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   initial begin : driver
      dir_step_type step;
      req_type      item;
      int           drain_count;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      width_setting  = GLYPH_WIDTH_RESET;
      height_setting = GLYPH_HEIGHT_RESET;
      layout_setting = LAYOUT_ROW_MAJOR;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < GLYPH_BYTES; i++) begin
         item            = random_req(KIND_LOAD);
         item.byte_index = BYTE_IDX_W'(i);
         send_item(item, 1'b0, '0, '0);
      end

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         step = DIRECTED[i];
         case (step.kind)
            STEP_CFG: begin
               write_csr(CSR_GLYPH_WIDTH, step.p0[DIM_W-1:0]);
               write_csr(CSR_GLYPH_HEIGHT, step.p1[DIM_W-1:0]);
               write_csr(CSR_LAYOUT_MODE, CSR_DATA_W'(step.p2[0]));
            end
            STEP_LOAD: begin
               item            = random_req(KIND_LOAD);
               item.byte_index = step.p0[BYTE_IDX_W-1:0];
               item.byte_value = step.p1[BYTE_BITS-1:0];
               send_item(item, 1'b0, '0, '0);
            end
            STEP_DRAW: begin
               item            = random_req(KIND_DRAW);
               item.origin_x   = step.p0;
               item.origin_y   = step.p1;
               item.draw_color = step.p2;
               send_item(item, step.typed, step.x_end, step.y_end);
            end
            default: begin
            end
         endcase
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         gaps_on = ((phase % 2) == 0);
         write_csr(CSR_GLYPH_WIDTH, CSR_DATA_W'($urandom_range((1 << DIM_W) - 1, 0)));
         write_csr(CSR_GLYPH_HEIGHT, CSR_DATA_W'($urandom_range((1 << DIM_W) - 1, 0)));
         write_csr(CSR_LAYOUT_MODE, CSR_DATA_W'($urandom_range(1, 0)));
         for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
            if ($urandom_range(99, 0) < DRAW_PERCENT) begin
               item = random_req(KIND_DRAW);
            end else begin
               item = random_req(KIND_LOAD);
            end
            send_item(item, 1'b0, '0, '0);
         end
      end

      start     <= 1'b0;
      csr_wr_en <= 1'b0;
      drain_count = 0;
      while (beats_due.size() != 0 && drain_count < DRAIN_CYCLES) begin
         @(posedge clock);
         drain_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (beats_due.size() != 0) begin
         flag_mismatch("results never seen", beats_due.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
